// ===== hdl/rtu_pkg.sv =====
`default_nettype none

package rtu_pkg;

	// Receive buffer size in bytes (4 .. 256)
	localparam int BUFFER_BYTES = 256;
	localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
	localparam int IDX_W        = 8;
	localparam int LEN_W        = 9;
	localparam int MIN_FRAME    = 4;

	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [15:0] TIMER_MAX   = 16'hFFFF;

	// Register reset values
	localparam logic [7:0]  DEV_ADDR_RST = 8'd0;
	localparam logic [15:0] GAP_RST      = 16'd750;
	localparam logic [15:0] END_RST      = 16'd1750;

	typedef logic [1:0] cfg_index_t;
	localparam cfg_index_t CFG_DEV_ADDR = 2'd0;
	localparam cfg_index_t CFG_GAP      = 2'd1;
	localparam cfg_index_t CFG_END      = 2'd2;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic KIND_BYTE    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_BROADCAST = 3'd1,
		ST_SHORT     = 3'd2,
		ST_OTHER     = 3'd3,
		ST_BAD_CRC   = 3'd4,
		ST_BROKEN    = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0]  station_addr;
		logic [15:0] gap_ticks;
		logic [15:0] end_ticks;
	} cfg_t;

	typedef struct packed {
		logic       command;
		logic [7:0] byte_value;
	} item_t;

	typedef struct packed {
		logic             kind;
		logic [7:0]       frame_byte;
		logic [IDX_W-1:0] byte_index;
		status_t          status;
		logic [7:0]       frame_address;
		logic [LEN_W-1:0] frame_length;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/rtu_cfg.sv =====
`default_nettype none

module rtu_cfg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire rtu_pkg::cfg_index_t cfg_index,
	input  wire logic [15:0]        cfg_data,
	output rtu_pkg::cfg_t           cfg
);
	import rtu_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.station_addr <= DEV_ADDR_RST;
			cfg_q.gap_ticks    <= GAP_RST;
			cfg_q.end_ticks    <= END_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DEV_ADDR: cfg_q.station_addr <= cfg_data[7:0];
				CFG_GAP:      cfg_q.gap_ticks    <= cfg_data;
				CFG_END:      cfg_q.end_ticks    <= cfg_data;
				default: ;    // unknown index ignored
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/rtu_engine.sv =====
`default_nettype none

module rtu_engine (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step_en,
	input  wire rtu_pkg::item_t  item,
	input  wire rtu_pkg::cfg_t   cfg,
	output logic                 res_valid,
	output rtu_pkg::result_t     res
);
	import rtu_pkg::*;

	typedef enum logic [1:0] {
		PH_SYNC,
		PH_IDLE,
		PH_RECV,
		PH_ENDW
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [15:0]      timer_q, timer_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [15:0]      crc_q, crc_d;
	logic [7:0]       older_q, older_d;
	logic [7:0]       newer_q, newer_d;
	logic [7:0]       first_q, first_d;
	logic             broken_q, broken_d;

	logic        is_tick;
	logic [15:0] timer_inc;
	logic        can_store;
	logic [15:0] crc_shift;
	status_t     clean_status;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) c = (c >> 1) ^ CRC_POLY;
			else      c = c >> 1;
		end
		return c;
	endfunction

	assign is_tick   = (item.command == CMD_TICK);
	assign timer_inc = (timer_q == TIMER_MAX) ? timer_q : timer_q + 16'd1;
	assign can_store = (count_q < CNT_W'(BUFFER_BYTES));
	assign crc_shift = crc_byte(crc_q, older_q);

	// Verdict ignoring the broken mark; CRC trailer is low byte first
	always_comb begin
		if (count_q < CNT_W'(MIN_FRAME))
			clean_status = ST_SHORT;
		else if (first_q != 8'd0 && first_q != cfg.station_addr)
			clean_status = ST_OTHER;
		else if ({newer_q, older_q} != crc_q)
			clean_status = ST_BAD_CRC;
		else if (first_q == 8'd0)
			clean_status = ST_BROADCAST;
		else
			clean_status = ST_ACCEPTED;
	end

	always_comb begin
		phase_d   = phase_q;
		timer_d   = timer_q;
		count_d   = count_q;
		crc_d     = crc_q;
		older_d   = older_q;
		newer_d   = newer_q;
		first_d   = first_q;
		broken_d  = broken_q;
		res_valid = 1'b0;
		res       = '0;
		res.status = ST_ACCEPTED;

		if (step_en) begin
			unique case (phase_q)
				PH_SYNC: begin
					if (!is_tick) begin
						timer_d = '0;
					end else begin
						timer_d = timer_inc;
						if (timer_inc >= cfg.end_ticks) phase_d = PH_IDLE;
					end
				end
				PH_IDLE: begin
					// first byte opens a frame; buffer is never full here
					if (!is_tick) begin
						count_d   = CNT_W'(1);
						crc_d     = CRC_INIT;
						older_d   = '0;
						newer_d   = item.byte_value;
						first_d   = item.byte_value;
						broken_d  = 1'b0;
						timer_d   = '0;
						phase_d   = PH_RECV;
						res_valid = 1'b1;
						res.kind       = KIND_BYTE;
						res.frame_byte = item.byte_value;
						res.byte_index = '0;
					end
				end
				PH_RECV: begin
					if (!is_tick) begin
						timer_d = '0;
						if (can_store) begin
							if (count_q >= CNT_W'(2)) crc_d = crc_shift;
							older_d   = newer_q;
							newer_d   = item.byte_value;
							count_d   = count_q + CNT_W'(1);
							res_valid = 1'b1;
							res.kind       = KIND_BYTE;
							res.frame_byte = item.byte_value;
							res.byte_index = IDX_W'(count_q);
						end
					end else begin
						timer_d = timer_inc;
						if (timer_inc >= cfg.gap_ticks) begin
							phase_d  = PH_ENDW;
							broken_d = 1'b0;
							if (timer_inc >= cfg.end_ticks) begin
								phase_d   = PH_IDLE;
								res_valid = 1'b1;
								res.kind          = KIND_VERDICT;
								res.status        = clean_status;
								res.frame_address = first_q;
								res.frame_length  = LEN_W'(count_q);
							end
						end
					end
				end
				PH_ENDW: begin
					if (!is_tick) begin
						broken_d = 1'b1;
						timer_d  = '0;
					end else begin
						timer_d = timer_inc;
						if (timer_inc >= cfg.end_ticks) begin
							phase_d   = PH_IDLE;
							res_valid = 1'b1;
							res.kind          = KIND_VERDICT;
							res.status        = broken_q ? ST_BROKEN : clean_status;
							res.frame_address = first_q;
							res.frame_length  = LEN_W'(count_q);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC;
			timer_q  <= '0;
			count_q  <= '0;
			crc_q    <= CRC_INIT;
			older_q  <= '0;
			newer_q  <= '0;
			first_q  <= '0;
			broken_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			timer_q  <= timer_d;
			count_q  <= count_d;
			crc_q    <= crc_d;
			older_q  <= older_d;
			newer_q  <= newer_d;
			first_q  <= first_d;
			broken_q <= broken_d;
		end
	end

	// A forwarded byte always leaves the block receiving
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_BYTE |=> phase_q == PH_RECV)
		else $error("byte forwarded outside reception");

	// A verdict always returns the block to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_VERDICT |=> phase_q == PH_IDLE)
		else $error("verdict did not return to idle");

	// Any received byte restarts the silence timer
	assert property (@(posedge clk) disable iff (!arst_n)
		step_en && item.command == CMD_BYTE |=> timer_q == 16'd0)
		else $error("byte did not restart silence timer");

	// An accepted frame holds at least address and CRC
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_VERDICT &&
		(res.status == ST_ACCEPTED || res.status == ST_BROADCAST)
		|-> res.frame_length >= LEN_W'(MIN_FRAME))
		else $error("short frame accepted");

	// Stored count never passes the buffer size
	assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> count_q <= CNT_W'(BUFFER_BYTES))
		else $error("stored count overflow");

endmodule

`default_nettype wire

// ===== hdl/rtu_frame_receiver.sv =====
// Path: an input transfer loads the input register, and its result then loads the result
//   register; the item waits in the input register while a held result is stalled.
// Throughput: one item per cycle; the single-pass step logic and the result register
//   set the rate, and input stall follows output stall only while a result is held.
// Items that produce no result (ticks, dropped bytes) still each take an engine step.
// Reset (arst_n low, asynchronous): line sync wait, empty pipeline, registers at
//   station address 0, gap time 750 ticks, end time 1750 ticks.
`default_nettype none

module rtu_frame_receiver (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// item channel
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                command,
	input  wire logic [7:0]          byte_value,
	// result channel
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     kind,
	output logic [7:0]               frame_byte,
	output logic [7:0]               byte_index,
	output logic [2:0]               status,
	output logic [7:0]               frame_address,
	output logic [8:0]               frame_length,
	// configuration write channel
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire rtu_pkg::cfg_index_t cfg_index,
	input  wire logic [15:0]         cfg_data
);
	import rtu_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	logic    step_valid;
	result_t step_res;
	result_t res_q;
	logic    res_valid_q;

	rtu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The stage-1 item moves on whenever the result register is empty or draining.
	assign advance  = valid_s1 && (!res_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register: reloads whenever it is not holding a stalled item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			item_s1.command    <= command;
			item_s1.byte_value <= byte_value;
		end
	end

	// Frame state and the per-item step
	rtu_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (step_valid),
		.res       (step_res)
	);

	// Result register: holds a result until its transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= step_valid;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_valid) begin
			res_q <= step_res;
		end
	end

	assign out_valid     = res_valid_q;
	assign kind          = res_q.kind;
	assign frame_byte    = res_q.frame_byte;
	assign byte_index    = res_q.byte_index;
	assign status        = res_q.status;
	assign frame_address = res_q.frame_address;
	assign frame_length  = res_q.frame_length;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import rtu_pkg::*;

	// Index 3 decodes to no register; writes to it must be dropped.
	localparam cfg_index_t CFG_UNMAPPED  = 2'd3;
	// Two-stage pipeline plus margin, waited out before any register write.
	localparam int         SETTLE_CYCLES = 6;
	// Upper bound on the length of a full run.
	localparam int         CYCLE_LIMIT   = 100_000;

	// Line state of the receiver as tracked on the bench side.
	typedef enum logic [1:0] {
		LINE_SYNC,
		LINE_IDLE,
		LINE_RECV,
		LINE_ENDW
	} line_phase_t;

	// Sender / receiver idling profiles, cycled over the random phases.
	typedef enum int {
		FLOW_FREE,
		FLOW_SENDER_GAPS,
		FLOW_RECEIVER_STALLS,
		FLOW_BOTH
	} flow_t;

	// Tracks the frame state machine, queues the results each transfer
	// should produce, and matches the block's results against them in order.
	class frame_tracker;
		logic [7:0]  dev_addr;
		logic [15:0] gap_lim;
		logic [15:0] end_lim;

		line_phase_t line_phase;
		logic [15:0] quiet;
		logic [8:0]  count;
		logic [15:0] crc;
		logic [7:0]  older;
		logic [7:0]  newer;
		logic [7:0]  head;
		logic        broken;

		result_t due_results[$];
		int      errors;
		int      bytes_ok;
		int      status_hits[6];

		function new();
			dev_addr   = 8'd0;
			gap_lim    = 16'd750;
			end_lim    = 16'd1750;
			line_phase = LINE_SYNC;
			quiet      = '0;
			count      = '0;
			crc        = 16'hFFFF;
			older      = '0;
			newer      = '0;
			head       = '0;
			broken     = 1'b0;
			errors     = 0;
			bytes_ok   = 0;
			foreach (status_hits[i]) status_hits[i] = 0;
		endfunction

		// CRC-16/MODBUS, reflected, one byte.
		static function logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
			logic [15:0] r;
			r = c ^ {8'h00, b};
			for (int k = 0; k < 8; k++)
				r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
			return r;
		endfunction

		function void write_reg(cfg_index_t idx, logic [15:0] d);
			case (idx)
				CFG_DEV_ADDR: dev_addr = d[7:0];
				CFG_GAP:      gap_lim = d;
				CFG_END:      end_lim = d;
				default: ;
			endcase
		endfunction

		function void tick_quiet();
			if (quiet != 16'hFFFF)
				quiet++;
		endfunction

		// CRC trails the stored stream by two bytes, so the last two
		// stored bytes are always the received check value.
		function void keep_byte(logic [7:0] b);
			result_t r;
			if (count >= BUFFER_BYTES)
				return;
			if (count == 0)
				head = b;
			if (count >= 2)
				crc = crc16_step(crc, older);
			older = newer;
			newer = b;
			r = '0;
			r.kind = KIND_BYTE;
			r.frame_byte = b;
			r.byte_index = count[7:0];
			count++;
			due_results.push_back(r);
		endfunction

		function void judge_frame();
			result_t r;
			status_t st;
			if (broken)
				st = ST_BROKEN;
			else if (count < MIN_FRAME)
				st = ST_SHORT;
			else if (head != 8'h00 && head != dev_addr)
				st = ST_OTHER;
			else if ({newer, older} != crc)
				st = ST_BAD_CRC;
			else if (head == 8'h00)
				st = ST_BROADCAST;
			else
				st = ST_ACCEPTED;
			r = '0;
			r.kind = KIND_VERDICT;
			r.status = st;
			r.frame_address = head;
			r.frame_length = count;
			due_results.push_back(r);
			line_phase = LINE_IDLE;
		endfunction

		// Advance on one accepted input transfer.
		function void line_event(logic cmd, logic [7:0] b);
			case (line_phase)
				LINE_SYNC: begin
					if (cmd == CMD_BYTE) begin
						quiet = '0;
					end else begin
						tick_quiet();
						if (quiet >= end_lim)
							line_phase = LINE_IDLE;
					end
				end
				LINE_IDLE: begin
					if (cmd == CMD_BYTE) begin
						count = '0;
						crc = 16'hFFFF;
						older = '0;
						newer = '0;
						broken = 1'b0;
						quiet = '0;
						line_phase = LINE_RECV;
						keep_byte(b);
					end
				end
				LINE_RECV: begin
					if (cmd == CMD_BYTE) begin
						quiet = '0;
						keep_byte(b);
					end else begin
						tick_quiet();
						if (quiet >= gap_lim) begin
							line_phase = LINE_ENDW;
							broken = 1'b0;
							if (quiet >= end_lim)
								judge_frame();
						end
					end
				end
				default: begin
					if (cmd == CMD_BYTE) begin
						broken = 1'b1;
						quiet = '0;
					end else begin
						tick_quiet();
						if (quiet >= end_lim)
							judge_frame();
					end
				end
			endcase
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 100)
				$display("ERROR @%0t: %s", $time, msg);
		endtask

		task match_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				report($sformatf("unexpected result %0d/%02h/%0d/%0d/%02h/%0d",
					got.kind, got.frame_byte, got.byte_index, got.status,
					got.frame_address, got.frame_length));
				return;
			end
			want = due_results.pop_front();
			if (got.kind !== want.kind || got.frame_byte !== want.frame_byte ||
					got.byte_index !== want.byte_index || got.status !== want.status ||
					got.frame_address !== want.frame_address ||
					got.frame_length !== want.frame_length) begin
				report($sformatf("got %0d/%02h/%0d/%0d/%02h/%0d want %0d/%02h/%0d/%0d/%02h/%0d",
					got.kind, got.frame_byte, got.byte_index, got.status,
					got.frame_address, got.frame_length,
					want.kind, want.frame_byte, want.byte_index, want.status,
					want.frame_address, want.frame_length));
			end else if (want.kind == KIND_BYTE) begin
				bytes_ok++;
			end else begin
				status_hits[int'(want.status)]++;
			end
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       command;
	logic [7:0] byte_value;
	logic       out_valid;
	logic       out_stall;
	logic       kind;
	logic [7:0] frame_byte;
	logic [7:0] byte_index;
	logic [2:0] status;
	logic [7:0] frame_address;
	logic [8:0] frame_length;
	logic       cfg_valid;
	logic       cfg_ready;
	cfg_index_t cfg_index;
	logic [15:0] cfg_data;

	frame_tracker sb = new();
	result_t      seen;
	int           idle_pct = 0;
	int           stall_pct = 0;
	int           items_sent = 0;
	int           settings_used = 0;
	int unsigned  cycle_count = 0;

	rtu_frame_receiver dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.byte_value    (byte_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.frame_byte    (frame_byte),
		.byte_index    (byte_index),
		.status        (status),
		.frame_address (frame_address),
		.frame_length  (frame_length),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Watchdog: a hung handshake ends up here.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results still due", cycle_count,
			sb.due_results.size());
		$display("rtu_frame_receiver: mismatch");
		$finish;
	end

	// Receiver side: stall decided at the falling edge, so it is stable
	// across the rising edge where the result transfer is sampled.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Result transfer = out_valid high and out_stall low at the rising edge.
	// Outputs read here still hold their pre-edge values.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			seen.kind = kind;
			seen.frame_byte = frame_byte;
			seen.byte_index = byte_index;
			seen.status = status_t'(status);
			seen.frame_address = frame_address;
			seen.frame_length = frame_length;
			sb.match_result(seen);
		end
	end

	task automatic set_flow(flow_t f);
		case (f)
			FLOW_FREE: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			FLOW_SENDER_GAPS: begin
				idle_pct = 58;
				stall_pct = 0;
			end
			FLOW_RECEIVER_STALLS: begin
				idle_pct = 0;
				stall_pct = 58;
			end
			default: begin
				idle_pct = 25;
				stall_pct = 25;
			end
		endcase
	endtask

	// Entered at a falling edge, returns at a falling edge with in_valid still
	// high; the next call either keeps it high or drops it for an idle cycle.
	task automatic send_item(input logic cmd, input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		byte_value <= b;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.line_event(cmd, b);
		items_sent++;
		@(negedge clk);
	endtask

	// Stop sending and let every due result come out, then let the pipeline
	// settle, since ticks and dropped bytes leave nothing to wait on.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.due_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// cfg_valid stays high across back-to-back writes; the caller drops it.
	task automatic put_reg(input cfg_index_t idx, input logic [15:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.write_reg(idx, d);
		@(negedge clk);
	endtask

	// Device address write carries random junk in the upper byte.
	task automatic configure(input logic [7:0] dev, input logic [15:0] gap,
			input logic [15:0] quiet_end, input bit poke);
		put_reg(CFG_DEV_ADDR, {8'($urandom), dev});
		put_reg(CFG_GAP, gap);
		put_reg(CFG_END, quiet_end);
		if (poke)
			put_reg(CFG_UNMAPPED, 16'($urandom));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Sends one frame: address, payload and, from four bytes up, the CRC low
	// byte first. spare bytes are appended after the CRC (overflow tests).
	// Short pauses between bytes stay under the gap time.
	task automatic send_frame(input logic [7:0] addr, input int len, input bit good_crc,
			input int spare);
		logic [7:0]  body[$];
		logic [15:0] c;
		int          lim;
		int          pause;
		body.push_back(addr);
		while (body.size() < len - ((len >= 4) ? 2 : 0))
			body.push_back(8'($urandom));
		if (len >= 4) begin
			c = 16'hFFFF;
			foreach (body[i]) c = frame_tracker::crc16_step(c, body[i]);
			body.push_back(c[7:0]);
			body.push_back(c[15:8]);
			if (!good_crc)
				body[len - 1 - $urandom_range(1)] ^= 8'h01 << $urandom_range(7);
		end
		repeat (spare) body.push_back(8'($urandom));
		lim = (sb.gap_lim > 3) ? 3 : ((sb.gap_lim == 0) ? 0 : sb.gap_lim - 1);
		foreach (body[i]) begin
			send_item(CMD_BYTE, body[i]);
			if (i + 1 < body.size() && lim > 0 && $urandom_range(3) == 0) begin
				pause = $urandom_range(lim);
				repeat (pause) send_item(CMD_TICK, 8'($urandom));
			end
		end
	endtask

	// Silence until the verdict. With break_it, once the gap has closed
	// reception, a few late bytes hit the end wait and spoil the frame.
	task automatic finish_frame(input bit break_it);
		int n;
		if (break_it) begin
			while (sb.line_phase == LINE_RECV)
				send_item(CMD_TICK, 8'($urandom));
			n = $urandom_range(2);
			while (n > 0 && sb.line_phase == LINE_ENDW && sb.quiet + 1 < sb.end_lim) begin
				send_item(CMD_TICK, 8'($urandom));
				n--;
			end
			n = $urandom_range(2, 1);
			while (n > 0 && sb.line_phase == LINE_ENDW) begin
				send_item(CMD_BYTE, 8'($urandom));
				n--;
			end
		end
		while (sb.line_phase != LINE_IDLE)
			send_item(CMD_TICK, 8'($urandom));
		// ticks on an idle line should do nothing
		repeat ($urandom_range(2)) send_item(CMD_TICK, 8'($urandom));
	endtask

	task automatic random_frame();
		logic [7:0] addr;
		int         len;
		int         sel;
		int         spare;
		sel = $urandom_range(99);
		if (sel < 40)
			addr = sb.dev_addr;
		else if (sel < 60)
			addr = 8'h00;
		else
			addr = 8'($urandom);
		sel = $urandom_range(99);
		spare = 0;
		if (sel < 70) begin
			len = $urandom_range(12, 4);
		end else if (sel < 85) begin
			len = $urandom_range(3, 1);
		end else if (sel < 99) begin
			len = $urandom_range(40, 13);
		end else begin
			len = $urandom_range(256, 250);
			spare = $urandom_range(4);
		end
		send_frame(addr, len, $urandom_range(99) < 80, spare);
		finish_frame($urandom_range(99) < 10);
	endtask

	// Unstructured bytes and ticks, then silence to get back to a known state.
	task automatic line_noise();
		int n;
		n = $urandom_range(8, 1);
		repeat (n) send_item($urandom_range(1), 8'($urandom));
		finish_frame(1'b0);
	endtask

	initial begin
		int         start;
		logic [7:0] dev;
		int         sel;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_BYTE;
		byte_value = 8'h00;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_DEV_ADDR;
		cfg_data = 16'h0000;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset register values: a byte during the line sync wait restarts
		// the 1750-tick end wait; the address register still reads zero, so
		// a nonzero address belongs to another station.
		set_flow(FLOW_FREE);
		repeat (20) send_item(CMD_TICK, 8'($urandom));
		send_item(CMD_BYTE, 8'hA5);
		finish_frame(1'b0);
		drain();
		put_reg(CFG_GAP, 16'd2);
		put_reg(CFG_END, 16'd3);
		cfg_valid <= 1'b0;
		send_frame(8'h5A, 6, 1'b1, 0);
		finish_frame(1'b0);
		drain();

		// One frame of each verdict.
		configure(8'h5A, 16'd3, 16'd6, 1'b1);
		send_frame(8'h5A, 4, 1'b1, 0);
		finish_frame(1'b0);
		send_frame(8'h00, 5, 1'b1, 0);
		finish_frame(1'b0);
		send_frame(8'h5A, 1, 1'b1, 0);
		finish_frame(1'b0);
		send_frame(8'h5A, 3, 1'b1, 0);
		finish_frame(1'b0);
		send_frame(8'hFF, 6, 1'b1, 0);
		finish_frame(1'b0);
		send_frame(8'h5A, 6, 1'b0, 0);
		finish_frame(1'b0);
		send_frame(8'h5A, 5, 1'b1, 0);
		finish_frame(1'b1);
		drain();

		// Zero timing values behave as one tick.
		configure(8'h01, 16'd0, 16'd0, 1'b0);
		set_flow(FLOW_SENDER_GAPS);
		send_frame(8'h01, 5, 1'b1, 0);
		finish_frame(1'b1);
		send_frame(8'h00, 4, 1'b1, 0);
		finish_frame(1'b0);
		drain();

		// End time below gap time: verdict on the tick that closes reception.
		configure(8'h22, 16'd5, 16'd2, 1'b0);
		set_flow(FLOW_RECEIVER_STALLS);
		send_frame(8'h22, 7, 1'b1, 0);
		finish_frame(1'b1);
		drain();

		// Lowest timing, and frames that fill the buffer and spill over.
		configure(8'h33, 16'd1, 16'd1, 1'b0);
		set_flow(FLOW_BOTH);
		send_frame(8'h33, 256, 1'b1, 4);
		finish_frame(1'b0);
		send_frame(8'h33, 256, 1'b0, 1);
		finish_frame(1'b0);
		drain();

		// Random frames under short random timing, cycling the idle profiles.
		for (int p = 0; p < 8; p++) begin
			sel = $urandom_range(99);
			if (sel < 20)
				dev = 8'h00;
			else if (sel < 30)
				dev = 8'hFF;
			else
				dev = 8'($urandom);
			configure(dev, 16'($urandom_range(6)), 16'($urandom_range(8)),
				$urandom_range(3) == 0);
			set_flow(flow_t'(p % 4));
			start = items_sent;
			while (items_sent - start < 30) begin
				if ($urandom_range(99) < 8)
					line_noise();
				else
					random_frame();
			end
			drain();
		end

		if (sb.due_results.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.due_results.size()));

		$display("covered %0d input transfers, %0d register settings, four idle profiles",
			items_sent, settings_used);
		$display("checked %0d bytes; acc %0d bcast %0d short %0d other %0d crc %0d broken %0d",
			sb.bytes_ok, sb.status_hits[ST_ACCEPTED], sb.status_hits[ST_BROADCAST],
			sb.status_hits[ST_SHORT], sb.status_hits[ST_OTHER], sb.status_hits[ST_BAD_CRC],
			sb.status_hits[ST_BROKEN]);
		if (sb.errors == 0) begin
			$display("rtu_frame_receiver: match");
		end else begin
			$display("rtu_frame_receiver: mismatch");
		end
		$finish;
	end

endmodule

// ===== rtu_frame_receiver.f =====
hdl/rtu_pkg.sv
hdl/rtu_cfg.sv
hdl/rtu_engine.sv
hdl/rtu_frame_receiver.sv
bench/tb.sv
